### rtl/adtd_pkg.sv
// Shared types, calibration table and fixed-point constants for the
// ADC-to-distance piecewise linear unit. No dependencies.
package adtd_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int DIST_W      = 10;
  localparam int TDATA_W     = 16;
  localparam int TABLE_SLOTS = 16;
  localparam int OFFS_W      = 10;
  localparam int Q_W         = 8;
  localparam int A_W         = 30;
  localparam int B_W         = 29;
  localparam int RECIP_SH    = 29;
  localparam int PROD_W      = 41;
  localparam int CFG_IDX_W   = 1;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [Q_W-1:0]      quot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DISTANCE = 1'b0,
    REG_MAX_DISTANCE = 1'b1
  } cfg_reg_t;

  localparam dist_t MIN_DIST_RST = 10'd64;
  localparam dist_t MAX_DIST_RST = 10'd800;

  localparam sample_t CAL_CODE [TABLE_SLOTS] = '{
    12'd2730, 12'd2631, 12'd2482, 12'd2196, 12'd1923, 12'd1688, 12'd1241, 12'd931,
    12'd335,  12'd335,  12'd335,  12'd335,  12'd335,  12'd335,  12'd335,  12'd335
  };

  localparam dist_t CAL_DIST [TABLE_SLOTS] = '{
    10'd64,  10'd96,  10'd160, 10'd240, 10'd320, 10'd400, 10'd480, 10'd640,
    10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800, 10'd800
  };

  // Selected segment: offset below the upper code, scaled slope and
  // rounding term (both pre-multiplied by the reciprocal), base distance
  typedef struct packed {
    logic [OFFS_W-1:0] offs;
    logic [A_W-1:0]    a;
    logic [B_W-1:0]    b;
    dist_t             dh;
  } seg_t;

endpackage

### rtl/adtd_seg_sel.sv
// Segment search for the ADC-to-distance unit: parallel range compares
// over the calibration table and selection of the segment constants. Uses adtd_pkg.
module adtd_seg_sel #(
  parameter int CALIB_POINTS = 9
) (
  input  adtd_pkg::sample_t sample,
  output adtd_pkg::seg_t    seg
);
  import adtd_pkg::*;

  localparam int LAST = CALIB_POINTS - 1;
  localparam int SEGS = CALIB_POINTS - 1;

  logic [SEGS-1:0] hit;
  seg_t            seg_tab [SEGS];

  for (genvar g = 0; g < SEGS; g++) begin : g_seg
    localparam int          DEN   = int'(CAL_CODE[g]) - int'(CAL_CODE[g+1]);
    localparam int          SLOPE = int'(CAL_DIST[g+1]) - int'(CAL_DIST[g]);
    localparam int          DIVR  = (DEN == 0) ? 1 : 2 * DEN;
    localparam longint      RECIP = (DEN == 0) ? 0 :
                                    ((longint'(1) << RECIP_SH) + DIVR - 1) / DIVR;
    localparam longint      SEG_A = 2 * SLOPE * RECIP;
    localparam longint      SEG_B = DEN * RECIP;

    assign hit[g]     = (sample <= CAL_CODE[g]) && (sample >= CAL_CODE[g+1]);
    assign seg_tab[g] = '{offs: OFFS_W'(CAL_CODE[g] - sample),
                          a:    A_W'(SEG_A),
                          b:    B_W'(SEG_B),
                          dh:   CAL_DIST[g]};
  end

  always_comb begin
    seg = '{offs: '0, a: '0, b: '0, dh: CAL_DIST[LAST]};
    if (sample >= CAL_CODE[0]) begin
      seg.dh = CAL_DIST[0];
    end else if (sample > CAL_CODE[LAST]) begin
      // first matching segment wins
      for (int i = SEGS - 1; i >= 0; i--) begin
        if (hit[i]) begin
          seg = seg_tab[i];
        end
      end
    end
  end

endmodule

### rtl/adtd_limit.sv
// Final add and saturation for the ADC-to-distance unit: base distance plus
// interpolated step, raised to the lower limit then lowered to the upper. Uses adtd_pkg.
module adtd_limit (
  input  adtd_pkg::dist_t dh,
  input  adtd_pkg::quot_t q,
  input  adtd_pkg::dist_t min_distance,
  input  adtd_pkg::dist_t max_distance,
  output adtd_pkg::dist_t distance
);
  import adtd_pkg::*;

  logic [DIST_W:0] sum;
  logic [DIST_W:0] low_sat;

  always_comb begin
    sum     = (DIST_W + 1)'(dh) + (DIST_W + 1)'(q);
    low_sat = (sum < (DIST_W + 1)'(min_distance)) ? (DIST_W + 1)'(min_distance) : sum;
    if (low_sat > (DIST_W + 1)'(max_distance)) begin
      distance = max_distance;
    end else begin
      distance = DIST_W'(low_sat);
    end
  end

endmodule

### rtl/adc_to_distance_piecewise_linear_unit.sv
// Top level of the ADC-to-distance piecewise linear unit: stream ports,
// limit registers and the three-register pipeline. Uses adtd_pkg, adtd_seg_sel, adtd_limit.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------
//   s_*      | in        | tdata[11:0] adc_sample, rest zero
//   m_*      | out       | tdata[9:0]  distance (1/16 cm), rest zero
//   cfg_*    | in        | index 0 min_distance, 1 max_distance
//
// One sample per cycle sustained while m_tready stays high; a result passes from
// the input register, through segment select and the reciprocal multiply into the middle
// register, then through add and saturation into the output register.
// Reset clears the valid flags and loads the limits to 64 and 800.
// Each register level advances when empty or when the level after it moves,
// so s_tready stays high while bubbles remain behind a stalled result.
module adc_to_distance_piecewise_linear_unit #(
  parameter int CALIB_POINTS = 9
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [adtd_pkg::TDATA_W-1:0]         s_tdata,   // [11:0] adc_sample
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [adtd_pkg::TDATA_W-1:0]         m_tdata,   // [9:0] distance
  input  logic                                 cfg_wen,
  input  logic [adtd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [adtd_pkg::DIST_W-1:0]          cfg_wdata
);
  import adtd_pkg::*;

  dist_t   min_distance;
  dist_t   max_distance;

  logic    in_valid;
  sample_t in_sample;
  logic    mid_valid;
  quot_t   mid_q;
  dist_t   mid_dh;
  logic    out_valid;
  dist_t   out_dist;

  logic    in_rdy;
  logic    mid_rdy;
  logic    out_rdy;

  seg_t              seg;
  logic [PROD_W-1:0] prod;
  quot_t             q_next;
  dist_t             dist_next;

  assign out_rdy  = !out_valid || m_tready;
  assign mid_rdy  = !mid_valid || out_rdy;
  assign in_rdy   = !in_valid || mid_rdy;
  assign s_tready = in_rdy;

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'(out_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DIST_RST;
      max_distance <= MAX_DIST_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DISTANCE: min_distance <= cfg_wdata;
        REG_MAX_DISTANCE: max_distance <= cfg_wdata;
        default: ;
      endcase
    end
  end

  adtd_seg_sel #(
    .CALIB_POINTS(CALIB_POINTS)
  ) u_seg_sel (
    .sample(in_sample),
    .seg   (seg)
  );

  always_comb begin
    prod   = PROD_W'(seg.offs) * PROD_W'(seg.a) + PROD_W'(seg.b);
    q_next = prod[RECIP_SH +: Q_W];
  end

  adtd_limit u_limit (
    .dh          (mid_dh),
    .q           (mid_q),
    .min_distance(min_distance),
    .max_distance(max_distance),
    .distance    (dist_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_valid <= s_tvalid;
      end
      if (mid_rdy) begin
        mid_valid <= in_valid;
      end
      if (out_rdy) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && s_tvalid) begin
      in_sample <= s_tdata[SAMPLE_W-1:0];
    end
    if (mid_rdy && in_valid) begin
      mid_q  <= q_next;
      mid_dh <= seg.dh;
    end
    if (out_rdy && mid_valid) begin
      out_dist <= dist_next;
    end
  end

endmodule

### rtl/adtd_checker.sv
// Port-level checks for the ADC-to-distance unit, bound to the top level.
// Mirrors the limit registers from the configuration port. Uses adtd_pkg.
module adtd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [adtd_pkg::TDATA_W-1:0]   m_tdata,
  input logic                           cfg_wen,
  input logic [adtd_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [adtd_pkg::DIST_W-1:0]    cfg_wdata
);
  import adtd_pkg::*;

  dist_t min_mirror;
  dist_t max_mirror;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mirror <= MIN_DIST_RST;
      max_mirror <= MAX_DIST_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DISTANCE: min_mirror <= cfg_wdata;
        REG_MAX_DISTANCE: max_mirror <= cfg_wdata;
        default: ;
      endcase
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready_on_drain: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid || !s_tvalid) && (!m_tvalid || m_tready) |-> s_tready)
    else $error("input held off although output side can move");

  a_upper_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[DIST_W-1:0] <= max_mirror) && (m_tdata[TDATA_W-1:DIST_W] == '0))
    else $error("distance above upper limit or padding not zero");

  a_lower_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (min_mirror <= max_mirror) |-> m_tdata[DIST_W-1:0] >= min_mirror)
    else $error("distance below lower limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown straight after reset");

endmodule

bind adc_to_distance_piecewise_linear_unit adtd_checker u_adtd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .cfg_wen  (cfg_wen),
  .cfg_index(cfg_index),
  .cfg_wdata(cfg_wdata)
);
